/* rtl/core/steering_angle_integrator_defines.svh */
// Assertion macros for the steering angle integrator.
`ifndef STEERING_ANGLE_INTEGRATOR_DEFINES_SVH
`define STEERING_ANGLE_INTEGRATOR_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SAI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Implication checked in the cycle after the antecedent.
`define SAI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* rtl/core/sai_pkg.sv */
// ----------------------------------------------------------------------------
// sai_pkg
// Types, constants and tables of the steering angle integrator.
// ----------------------------------------------------------------------------
package sai_pkg;

  localparam int CoordBits     = 12;
  localparam int AngleFracBits = 10;
  localparam int AngleBits     = 17;
  localparam int QuadBits      = 3;
  localparam int OutcomeBits   = 2;
  localparam int CfgIdxBits    = 2;
  localparam int CordicSteps   = 18;
  localparam int StepBits      = 5;
  // cordic operands: 13 bits of magnitude shifted by 14, with growth headroom
  localparam int CordicBits    = 30;
  localparam int ZBits         = 24;

  localparam logic [CfgIdxBits-1:0] CfgCenterX = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgCenterY = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgDeadRad = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgBand    = 2'd3;

  localparam logic [OutcomeBits-1:0] OutIgnored = 2'd0;
  localparam logic [OutcomeBits-1:0] OutCommit  = 2'd1;
  localparam logic [OutcomeBits-1:0] OutRotHold = 2'd2;
  localparam logic [OutcomeBits-1:0] OutCmtHold = 2'd3;

  localparam logic [QuadBits-1:0] QuadNone = 3'd0;
  localparam logic [QuadBits-1:0] Quad1    = 3'd1;
  localparam logic [QuadBits-1:0] Quad2    = 3'd2;
  localparam logic [QuadBits-1:0] Quad3    = 3'd3;
  localparam logic [QuadBits-1:0] Quad4    = 3'd4;

  localparam logic signed [ZBits-1:0] Deg90 = 24'sd5898240;
  localparam logic [12:0] BendDistance = 13'd1300;
  localparam logic signed [AngleBits-1:0] RotLimit  = 17'sd34816;
  localparam logic signed [AngleBits-1:0] BendLimit = 17'sd61440;

  typedef enum logic [3:0] {
    StIdle, StRotInit, StRotRun, StBendInit, StBendRun, StStep, StCommit,
    StMapNum, StMapDiv, StOut
  } state_e;

  typedef struct packed {
    logic load;       // capture point, compute deltas
    logic cor_init_rot;
    logic cor_init_bend;
    logic cor_step;
    logic latch_step;
    logic commit;
    logic map_num;
    logic map_div;
    logic ignore;
  } cmd_t;

  typedef struct packed {
    logic in_radius;
    logic last_step;
  } sts_t;

  function automatic logic signed [ZBits-1:0] atan_lut(input logic [StepBits-1:0] i);
    logic signed [ZBits-1:0] v;
    case (i)
      5'd0:  v = 24'sd2949120;
      5'd1:  v = 24'sd1740967;
      5'd2:  v = 24'sd919879;
      5'd3:  v = 24'sd466945;
      5'd4:  v = 24'sd234379;
      5'd5:  v = 24'sd117304;
      5'd6:  v = 24'sd58666;
      5'd7:  v = 24'sd29335;
      5'd8:  v = 24'sd14668;
      5'd9:  v = 24'sd7334;
      5'd10: v = 24'sd3667;
      5'd11: v = 24'sd1833;
      5'd12: v = 24'sd917;
      5'd13: v = 24'sd458;
      5'd14: v = 24'sd229;
      5'd15: v = 24'sd115;
      5'd16: v = 24'sd57;
      5'd17: v = 24'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

  // offset*1024000 + milli*angle
  function automatic logic signed [40:0] motor_num(input logic signed [AngleBits-1:0] ang,
                                                   input logic signed [15:0] milli,
                                                   input logic [11:0] offset);
    logic signed [32:0] prod;
    prod = 33'(milli) * 33'(ang);
    return 41'(signed'({1'b0, offset})) * 41'sd1024000 + 41'(prod);
  endfunction

  // round half up of num/1024000, saturated 0..4095; num stays below 2^32
  // divide by 8192, then by 125 through the reciprocal ceil(2^26/125)
  function automatic logic [CoordBits-1:0] motor_div(input logic signed [40:0] num);
    logic [40:0] s;
    logic [38:0] prod;
    s = unsigned'(num) + 41'd512000;
    prod = s[31:13] * 20'd536871;
    if (num <= 0) return '0;
    if (prod[38:26] > 13'd4095) return 12'd4095;
    return prod[37:26];
  endfunction

endpackage

/* rtl/core/sai_if.sv */
// ----------------------------------------------------------------------------
// sai_point_if / sai_result_if
// Valid/ready channels of the steering angle integrator.
// ----------------------------------------------------------------------------
interface sai_point_if import sai_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] point_x;
  logic [CoordBits-1:0] point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface sai_result_if import sai_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [CoordBits-1:0]          motor_rotation;
  logic [CoordBits-1:0]          motor_bending;
  logic signed [AngleBits-1:0]   rotation_angle;
  logic signed [AngleBits-1:0]   bending_angle;
  logic [QuadBits-1:0]           quadrant;
  logic [OutcomeBits-1:0]        outcome;
  modport source (output valid, motor_rotation, motor_bending, rotation_angle,
                  bending_angle, quadrant, outcome, input ready);
  modport sink   (input valid, motor_rotation, motor_bending, rotation_angle,
                  bending_angle, quadrant, outcome, output ready);
endinterface

/* rtl/core/steering_angle_integrator.sv */
// ----------------------------------------------------------------------------
// steering_angle_integrator
// Integrates rotation and bending angles from one target point per frame.
// ----------------------------------------------------------------------------
// channel   dir  payload
// pt        in   point_x, point_y
// res       out  motor_rotation, motor_bending, rotation_angle, bending_angle,
//                quadrant, outcome
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
// An inside point has its result valid after two 18-step cordic passes on one
// shared unit, the step latch, the commit and the numerator and divide mapping
// states; an ignored point right after the radius test. One item at a time.
// Reset restores the default registers and clears angles and setpoints.
// The result holds until taken; the next point is accepted the cycle after.
module steering_angle_integrator import sai_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CoordBits-1:0]  cfg_data_i,
  sai_point_if.sink             pt,
  sai_result_if.source          res
);

  cmd_t cmd;
  sts_t sts;

  sai_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (pt.valid), .in_ready_o (pt.ready),
    .out_valid_o(res.valid), .out_ready_i(res.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  sai_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .point_x_i(pt.point_x), .point_y_i(pt.point_y),
    .cmd_i(cmd), .sts_o(sts),
    .motor_rotation_o(res.motor_rotation), .motor_bending_o(res.motor_bending),
    .rotation_angle_o(res.rotation_angle), .bending_angle_o(res.bending_angle),
    .quadrant_o(res.quadrant), .outcome_o(res.outcome)
  );

endmodule

/* rtl/core/sai_ctrl.sv */
// ----------------------------------------------------------------------------
// sai_ctrl
// Sequencer: for inside points two cordic passes, commit, mapping; handshake.
// ----------------------------------------------------------------------------
module sai_ctrl import sai_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:     if (in_valid_i) state_d = StRotInit;
      StRotInit:  state_d = sts_i.in_radius ? StRotRun : StOut;
      StRotRun:   if (sts_i.last_step) state_d = StBendInit;
      StBendInit: state_d = StBendRun;
      StBendRun:  if (sts_i.last_step) state_d = StStep;
      StStep:     state_d = StCommit;
      StCommit:   state_d = StMapNum;
      StMapNum:   state_d = StMapDiv;
      StMapDiv:   state_d = StOut;
      StOut:      if (out_ready_i) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StRotInit: begin
        cmd_o.cor_init_rot = sts_i.in_radius;
        cmd_o.ignore       = !sts_i.in_radius;
      end
      StRotRun:   cmd_o.cor_step = 1'b1;
      StBendInit: cmd_o.cor_init_bend = 1'b1;
      StBendRun:  cmd_o.cor_step = 1'b1;
      StStep:     cmd_o.latch_step = 1'b1;
      StCommit:   cmd_o.commit = 1'b1;
      StMapNum:   cmd_o.map_num = 1'b1;
      StMapDiv:   cmd_o.map_div = 1'b1;
      StOut:      out_valid_o = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/sai_datapath.sv */
// ----------------------------------------------------------------------------
// sai_datapath
// Deltas, radius test, shared cordic, angle integration and motor mapping.
// ----------------------------------------------------------------------------
module sai_datapath import sai_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [CoordBits-1:0]        cfg_data_i,
  input  logic [CoordBits-1:0]        point_x_i,
  input  logic [CoordBits-1:0]        point_y_i,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  output logic [CoordBits-1:0]        motor_rotation_o,
  output logic [CoordBits-1:0]        motor_bending_o,
  output logic signed [AngleBits-1:0] rotation_angle_o,
  output logic signed [AngleBits-1:0] bending_angle_o,
  output logic [QuadBits-1:0]         quadrant_o,
  output logic [OutcomeBits-1:0]      outcome_o
);

  logic [CoordBits-1:0] cx_q, cy_q, rad_q, band_q;
  logic [CoordBits-1:0] adx_q, ady_q;
  logic right_q, upper_q, in_radius_q;
  logic signed [CordicBits-1:0] x_q, y_q;
  logic signed [ZBits-1:0] z_q, z_rot_q;
  logic [StepBits-1:0] i_q;
  logic zero_q, full_q, zero_rot_q, full_rot_q;
  logic signed [AngleBits-1:0] rot_step_q;
  logic signed [AngleBits:0] bend_step_q;
  logic signed [AngleBits-1:0] nrot_q, nbend_q;
  logic upd_rot_q, upd_bend_q;
  logic signed [40:0] num_rot_q, num_bend_q;
  logic signed [AngleBits-1:0] rot_q, bend_q;
  logic [QuadBits-1:0] quad_q;
  logic [CoordBits-1:0] mrot_q, mbend_q;
  logic [OutcomeBits-1:0] outcome_q;

  logic signed [CoordBits:0] dx, dy;
  logic [2*CoordBits+1:0] dist2, rad2;
  logic signed [CordicBits-1:0] x_sh, y_sh, x_n, y_n;
  logic signed [ZBits-1:0] z_n, a_rot, a_bend;
  logic [ZBits-1:0] rot_bias;
  logic [32:0] rot_prod;
  logic [ZBits+AngleFracBits-1:0] bend_num;
  logic signed [AngleBits-1:0] rot_step;
  logic signed [AngleBits:0] bend_step;
  logic signed [AngleBits+1:0] rot_sum, bend_sum;
  logic signed [AngleBits-1:0] new_rot, new_bend;
  logic [QuadBits-1:0] q;
  logic rot_hold, cmt_hold;

  assign dx = signed'({1'b0, point_x_i}) - signed'({1'b0, cx_q});
  assign dy = signed'({1'b0, point_y_i}) - signed'({1'b0, cy_q});
  assign dist2 = 26'((dx < 0 ? -dx : dx) * (dx < 0 ? -dx : dx))
               + 26'((dy < 0 ? -dy : dy) * (dy < 0 ? -dy : dy));
  assign rad2 = 26'(rad_q * rad_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= 12'd940; cy_q <= 12'd555; rad_q <= 12'd125; band_q <= 12'd125;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCenterX: cx_q <= cfg_data_i;
        CfgCenterY: cy_q <= cfg_data_i;
        CfgDeadRad: rad_q <= cfg_data_i;
        CfgBand:    band_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // cordic iteration
  assign x_sh = x_q >>> i_q;
  assign y_sh = y_q >>> i_q;
  always_comb begin
    if (y_q > 0) begin
      x_n = x_q + y_sh; y_n = y_q - x_sh; z_n = z_q + atan_lut(i_q);
    end else begin
      x_n = x_q - y_sh; y_n = y_q + x_sh; z_n = z_q - atan_lut(i_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      adx_q       <= CoordBits'(dx < 0 ? -dx : dx);
      ady_q       <= CoordBits'(dy < 0 ? -dy : dy);
      right_q     <= !dx[CoordBits];
      upper_q     <= dy <= 0;
      in_radius_q <= dist2 < rad2;
    end
    if (cmd_i.cor_init_rot) begin
      x_q <= CordicBits'({ady_q, 14'd0});
      y_q <= CordicBits'({adx_q, 14'd0});
      z_q <= '0; i_q <= '0;
      zero_q <= adx_q == '0; full_q <= ady_q == '0;
    end else if (cmd_i.cor_init_bend) begin
      z_rot_q <= z_q; zero_rot_q <= zero_q; full_rot_q <= full_q;
      x_q <= CordicBits'({BendDistance, 14'd0});
      y_q <= CordicBits'({ady_q, 14'd0});
      z_q <= '0; i_q <= '0;
      zero_q <= ady_q == '0; full_q <= 1'b0;
    end else if (cmd_i.cor_step) begin
      x_q <= x_n; y_q <= y_n; z_q <= z_n; i_q <= i_q + 1'b1;
    end
    if (cmd_i.latch_step) begin
      rot_step_q  <= rot_step;
      bend_step_q <= bend_step;
    end
    if (cmd_i.commit) begin
      nrot_q     <= new_rot;
      nbend_q    <= new_bend;
      upd_rot_q  <= !rot_hold;
      upd_bend_q <= !cmt_hold;
    end
    if (cmd_i.map_num) begin
      num_rot_q  <= motor_num(nrot_q, -16'sd17755, 12'd2810);
      num_bend_q <= (q == Quad1 || q == Quad2) ? motor_num(nbend_q, 16'sd5750, 12'd2384)
                                               : motor_num(nbend_q, 16'sd5432, 12'd2415);
    end
  end

  assign sts_o.in_radius = in_radius_q;
  assign sts_o.last_step = i_q == StepBits'(CordicSteps - 1);

  function automatic logic signed [ZBits-1:0] atan_fix(input logic signed [ZBits-1:0] z,
                                                       input logic zero, input logic full);
    if (zero) return '0;
    if (full) return Deg90;
    if (z < 0) return '0;
    if (z > Deg90) return Deg90;
    return z;
  endfunction

  assign a_rot  = atan_fix(z_rot_q, zero_rot_q, full_rot_q);
  assign a_bend = atan_fix(z_q, zero_q, full_q);
  // rotation step = floor((a + 320) / 640): shift by 7, then /5 by reciprocal
  assign rot_bias  = unsigned'(a_rot) + 24'd320;
  assign rot_prod  = rot_bias[22:7] * 17'd52429;
  assign rot_step  = signed'({2'b00, rot_prod[32:18]});
  assign bend_num  = {a_bend[ZBits-2:0], 10'd0, 1'b0} >> 1;
  assign bend_step = (AngleBits+1)'((bend_num + 34'd32768) >> 16);

  assign q = right_q ? (upper_q ? Quad1 : Quad4) : (upper_q ? Quad2 : Quad3);
  assign rot_hold = (ady_q < band_q) &&
    ((q == Quad1 && quad_q == Quad4) || (q == Quad4 && quad_q == Quad1) ||
     (q == Quad2 && quad_q == Quad3) || (q == Quad3 && quad_q == Quad2));
  assign cmt_hold = q == Quad1 && quad_q == Quad3;

  assign rot_sum = (q == Quad1 || q == Quad3) ? 19'(rot_q) + 19'(rot_step_q)
                                              : 19'(rot_q) - 19'(rot_step_q);
  assign bend_sum = (q == Quad1 || q == Quad2) ? 19'(bend_q) - 19'(bend_step_q)
                                               : 19'(bend_q) + 19'(bend_step_q);
  assign new_rot = rot_hold ? rot_q :
                   rot_sum > 19'(RotLimit) ? RotLimit :
                   rot_sum < -19'(RotLimit) ? -RotLimit : AngleBits'(rot_sum);
  assign new_bend = bend_sum > 19'(BendLimit) ? BendLimit :
                    bend_sum < -19'(BendLimit) ? -BendLimit : AngleBits'(bend_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= '0; bend_q <= '0; quad_q <= QuadNone;
      mrot_q <= '0; mbend_q <= '0; outcome_q <= OutIgnored;
    end else if (cmd_i.ignore) begin
      outcome_q <= OutIgnored;
    end else if (cmd_i.commit) begin
      if (cmt_hold) begin
        outcome_q <= OutCmtHold;
      end else begin
        rot_q  <= new_rot;
        bend_q <= new_bend;
        quad_q <= q;
        outcome_q <= rot_hold ? OutRotHold : OutCommit;
      end
    end else if (cmd_i.map_div) begin
      if (upd_rot_q) mrot_q <= motor_div(num_rot_q);
      if (upd_bend_q) mbend_q <= motor_div(num_bend_q);
    end
  end

  assign motor_rotation_o = mrot_q;
  assign motor_bending_o  = mbend_q;
  assign rotation_angle_o = rot_q;
  assign bending_angle_o  = bend_q;
  assign quadrant_o       = quad_q;
  assign outcome_o        = outcome_q;

endmodule

/* rtl/core/sai_checker.sv */
// ----------------------------------------------------------------------------
// sai_checker
// Port-level checks of the steering angle integrator.
// ----------------------------------------------------------------------------
`include "steering_angle_integrator_defines.svh"

module sai_checker import sai_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [QuadBits-1:0] quadrant,
  input logic [OutcomeBits-1:0] outcome,
  input logic signed [AngleBits-1:0] rotation_angle
);

  `SAI_ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, out_valid, !in_ready)
  `SAI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `SAI_ASSERT_IMPL(a_quad_range, clk_i, rst_ni, out_valid, quadrant <= Quad4)
  `SAI_ASSERT_IMPL(a_commit_quad, clk_i, rst_ni,
    out_valid && (outcome == OutCommit || outcome == OutRotHold), quadrant != QuadNone)
  `SAI_ASSERT_IMPL(a_rot_limit, clk_i, rst_ni, out_valid,
    rotation_angle <= RotLimit && rotation_angle >= -RotLimit)

endmodule

bind steering_angle_integrator sai_checker u_sai_checker (
  .clk_i, .rst_ni,
  .in_ready(pt.ready),
  .out_valid(res.valid), .out_ready(res.ready),
  .quadrant(res.quadrant), .outcome(res.outcome),
  .rotation_angle(res.rotation_angle)
);
